### sv/nnfm_pkg.sv
package nnfm_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned DEF_MAX_FACES  = 64;
  localparam int unsigned DEF_MAX_COEFFS = 64;
  localparam int unsigned DEF_COEFF_BITS = 20;

  // fixed field widths
  localparam int unsigned FACE_IDX_W  = 6;
  localparam int unsigned COEFF_IDX_W = 6;
  localparam int unsigned LABEL_W     = 16;
  localparam int unsigned DIST_W      = 31;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned CFG_W       = 31;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FUNC_W      = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_FACE_COUNT      = 7'd64;
  localparam logic [CNT_W-1:0]  RST_COEFF_COUNT     = 7'd64;
  localparam logic [CFG_W-1:0]  RST_MATCH_THRESHOLD = 31'd10000000;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_COEFF = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_LABEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_LABEL,
    ST_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic issue;
    logic first_coeff;
    logic last_coeff;
    logic last_face;
    logic label_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic best_done;
    logic out_free;
  } dp_status_t;

endpackage

### sv/nnfm_ctrl.sv
module nnfm_ctrl import nnfm_pkg::*; #(
  parameter int unsigned MAX_FACES  = DEF_MAX_FACES,
  parameter int unsigned MAX_COEFFS = DEF_MAX_COEFFS,
  localparam int unsigned FACE_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1,
  localparam int unsigned CI_W   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic              last_i,
  input  logic [CNT_W-1:0]  face_count_i,
  input  logic [CNT_W-1:0]  coeff_count_i,
  input  dp_status_t        status_i,
  output dp_cmd_t           cmd_o,
  output logic [FACE_W-1:0] face_o,
  output logic [CI_W-1:0]   coeff_o
);

  localparam int unsigned NF_W = ($clog2(MAX_FACES + 1) > CNT_W) ?
                                 $clog2(MAX_FACES + 1) : CNT_W;
  localparam int unsigned NC_W = ($clog2(MAX_COEFFS + 1) > CNT_W) ?
                                 $clog2(MAX_COEFFS + 1) : CNT_W;

  ctrl_state_e       state_q, state_d;
  logic [FACE_W-1:0] face_q, face_d;
  logic [CI_W-1:0]   coeff_q, coeff_d;
  logic [NF_W-1:0]   fc_ext, nf;
  logic [NC_W-1:0]   cc_ext, nc;
  logic              last_face, last_coeff;

  // effective counts: zero acts as one, large values clamp to the store size
  always_comb begin
    fc_ext = NF_W'(face_count_i);
    cc_ext = NC_W'(coeff_count_i);
    if (fc_ext == '0) begin
      nf = NF_W'(1);
    end else if (fc_ext > NF_W'(MAX_FACES)) begin
      nf = NF_W'(MAX_FACES);
    end else begin
      nf = fc_ext;
    end
    if (cc_ext == '0) begin
      nc = NC_W'(1);
    end else if (cc_ext > NC_W'(MAX_COEFFS)) begin
      nc = NC_W'(MAX_COEFFS);
    end else begin
      nc = cc_ext;
    end
  end

  assign last_face  = (NF_W'(face_q) + NF_W'(1)) == nf;
  assign last_coeff = (NC_W'(coeff_q) + NC_W'(1)) == nc;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (func_i == FUNC_QUERY) && last_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_coeff && last_face) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status_i.best_done) begin
          state_d = ST_LABEL;
        end
      end
      ST_LABEL: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.issue       = (state_q == ST_RUN);
    cmd_o.first_coeff = (coeff_q == '0);
    cmd_o.last_coeff  = last_coeff;
    cmd_o.last_face   = last_face;
    cmd_o.label_rd    = (state_q == ST_LABEL);
    cmd_o.out_load    = (state_q == ST_HOLD) && status_i.out_free;
  end

  // face and coefficient walk
  always_comb begin
    face_d  = face_q;
    coeff_d = coeff_q;
    if (state_q == ST_IDLE) begin
      face_d  = '0;
      coeff_d = '0;
    end else if (state_q == ST_RUN) begin
      if (last_coeff) begin
        coeff_d = '0;
        face_d  = face_q + FACE_W'(1);
      end else begin
        coeff_d = coeff_q + CI_W'(1);
      end
    end
  end

  assign face_o  = face_q;
  assign coeff_o = coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      face_q  <= '0;
      coeff_q <= '0;
    end else begin
      state_q <= state_d;
      face_q  <= face_d;
      coeff_q <= coeff_d;
    end
  end

endmodule

### sv/nnfm_dp.sv
module nnfm_dp import nnfm_pkg::*; #(
  parameter int unsigned MAX_FACES  = DEF_MAX_FACES,
  parameter int unsigned MAX_COEFFS = DEF_MAX_COEFFS,
  parameter int unsigned COEFF_BITS = DEF_COEFF_BITS,
  localparam int unsigned FACE_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1,
  localparam int unsigned CI_W   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_accept_i,
  input  logic [FUNC_W-1:0]      func_i,
  input  logic [FACE_IDX_W-1:0]  face_index_i,
  input  logic [COEFF_IDX_W-1:0] coeff_index_i,
  input  logic [COEFF_BITS-1:0]  coeff_value_i,
  input  logic [LABEL_W-1:0]     person_label_i,
  input  logic [CFG_W-1:0]       match_threshold_i,
  input  dp_cmd_t                cmd_i,
  input  logic [FACE_W-1:0]      face_i,
  input  logic [CI_W-1:0]        coeff_i,
  output dp_status_t             status_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [FACE_IDX_W-1:0]  nearest_index_o,
  output logic [LABEL_W-1:0]     person_o,
  output logic [DIST_W-1:0]      distance_o,
  output logic                   matched_o
);

  localparam int unsigned TRAIN_DEPTH = MAX_FACES * MAX_COEFFS;
  localparam int unsigned TA_W  = $clog2(TRAIN_DEPTH);
  localparam int unsigned SQ_W  = 2 * COEFF_BITS;
  localparam int unsigned ACC_W = (SQ_W + 8 > 64) ? 64 : SQ_W + 8;
  localparam int unsigned CMP_W = (ACC_W > DIST_W) ? ACC_W : DIST_W;

  typedef struct packed {
    logic              vld;
    logic              first;
    logic              lastc;
    logic              lastf;
    logic [FACE_W-1:0] face;
  } tag_t;

  logic [COEFF_BITS-1:0] train_mem [TRAIN_DEPTH];
  logic [LABEL_W-1:0]    label_mem [MAX_FACES];
  logic [COEFF_BITS-1:0] query_mem [MAX_COEFFS];

  logic                  train_we, label_we, query_we;
  logic [TA_W-1:0]       train_waddr, train_raddr;
  logic [COEFF_BITS-1:0] train_rd_q, query_rd_q;
  logic [LABEL_W-1:0]    label_q;

  tag_t                  tag1_q, tag2_q, tag3_q, tag4_q;
  logic signed [COEFF_BITS:0] diff;
  logic [COEFF_BITS:0]   mag_full;
  logic [COEFF_BITS-1:0] mag_q;
  logic [SQ_W-1:0]       sq_q;
  logic [ACC_W:0]        acc_sum;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [ACC_W-1:0]      best_d_q;
  logic [FACE_W-1:0]     best_i_q;
  logic                  best_done_q;
  logic [CMP_W-1:0]      best_ext;
  logic                  out_valid_q;

  // load decode, out of range loads are dropped
  assign train_we = in_accept_i && (func_i == FUNC_LOAD_COEFF) &&
                    (32'(face_index_i) < MAX_FACES) && (32'(coeff_index_i) < MAX_COEFFS);
  assign label_we = in_accept_i && (func_i == FUNC_LOAD_LABEL) &&
                    (32'(face_index_i) < MAX_FACES);
  assign query_we = in_accept_i && (func_i == FUNC_QUERY) &&
                    (32'(coeff_index_i) < MAX_COEFFS);

  assign train_waddr = TA_W'(32'(face_index_i) * MAX_COEFFS + 32'(coeff_index_i));
  assign train_raddr = TA_W'(32'(face_i) * MAX_COEFFS + 32'(coeff_i));

  always_ff @(posedge clk_i) begin
    if (train_we) begin
      train_mem[train_waddr] <= coeff_value_i;
    end
    if (cmd_i.issue) begin
      train_rd_q <= train_mem[train_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_we) begin
      query_mem[CI_W'(coeff_index_i)] <= coeff_value_i;
    end
    if (cmd_i.issue) begin
      query_rd_q <= query_mem[coeff_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (label_we) begin
      label_mem[FACE_W'(face_index_i)] <= person_label_i;
    end
    if (cmd_i.label_rd) begin
      label_q <= label_mem[best_i_q];
    end
  end

  // difference magnitude, fits coeff width
  assign diff = $signed({query_rd_q[COEFF_BITS-1], query_rd_q}) -
                $signed({train_rd_q[COEFF_BITS-1], train_rd_q});
  assign mag_full = diff[COEFF_BITS] ? (COEFF_BITS+1)'(-diff) : (COEFF_BITS+1)'(diff);

  // saturating accumulate
  assign acc_sum = {1'b0, acc_q} + (ACC_W+1)'(sq_q);
  always_comb begin
    if (tag3_q.first) begin
      acc_d = ACC_W'(sq_q);
    end else if (acc_sum[ACC_W]) begin
      acc_d = '1;
    end else begin
      acc_d = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      tag3_q      <= '0;
      tag4_q      <= '0;
      best_done_q <= 1'b0;
    end else begin
      tag1_q      <= '{vld: cmd_i.issue, first: cmd_i.first_coeff, lastc: cmd_i.last_coeff,
                       lastf: cmd_i.last_face, face: face_i};
      tag2_q      <= tag1_q;
      tag3_q      <= tag2_q;
      tag4_q      <= tag3_q;
      best_done_q <= tag4_q.vld && tag4_q.lastc && tag4_q.lastf;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_full[COEFF_BITS-1:0];
    sq_q  <= SQ_W'(mag_q) * SQ_W'(mag_q);
    if (tag3_q.vld) begin
      acc_q <= acc_d;
    end
    // lower index wins a tie
    if (tag4_q.vld && tag4_q.lastc) begin
      if ((tag4_q.face == '0) || (acc_q < best_d_q)) begin
        best_d_q <= acc_q;
        best_i_q <= tag4_q.face;
      end
    end
  end

  // result register
  assign best_ext = CMP_W'(best_d_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      nearest_index_o <= FACE_IDX_W'(best_i_q);
      person_o        <= label_q;
      distance_o      <= (best_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(best_ext);
      matched_o       <= best_ext < CMP_W'(match_threshold_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.best_done  = best_done_q;

endmodule

### sv/nearest_neighbour_face_match_core.sv
// nearest neighbour face matcher. training coefficient vectors and person labels are
// loaded one beat each (func 0 and 1), then a query arrives one coefficient per beat
// (func 2); the query beat flagged last starts a search over the first face_count faces
// and coeff_count coefficients, and one result beat carries the closest face index,
// its label, the squared euclidean distance saturated to 2^31-1 and a match flag
// (exact distance below match_threshold); ties go to the lower face index. load beats
// and ordinary query beats are accepted back to back while idle. a search keeps the input
// closed until its result enters the output register; the search is paced by the single
// subtract-square-accumulate unit walking one training coefficient per cycle out of
// the coefficient memory. the result sits in an output register; loads are taken while
// it waits, a new search finishes but holds until that register is free. stores hold
// no reset value: entries must be written before a search reads them. configuration
// writes are taken at any edge with cfg_we_i high and must only happen while idle.
module nearest_neighbour_face_match_core import nnfm_pkg::*; #(
  parameter int unsigned MAX_FACES  = DEF_MAX_FACES,
  parameter int unsigned MAX_COEFFS = DEF_MAX_COEFFS,
  parameter int unsigned COEFF_BITS = DEF_COEFF_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // input beats
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [FUNC_W-1:0]      func_i,
  input  logic [FACE_IDX_W-1:0]  face_index_i,
  input  logic [COEFF_IDX_W-1:0] coeff_index_i,
  input  logic [COEFF_BITS-1:0]  coeff_value_i,
  input  logic [LABEL_W-1:0]     person_label_i,
  input  logic                   last_i,
  // result beats
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [FACE_IDX_W-1:0]  nearest_index_o,
  output logic [LABEL_W-1:0]     person_o,
  output logic [DIST_W-1:0]      distance_o,
  output logic                   matched_o
);

  localparam int unsigned FACE_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int unsigned CI_W   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

  logic [CNT_W-1:0]  face_count_q;
  logic [CNT_W-1:0]  coeff_count_q;
  logic [CFG_W-1:0]  match_threshold_q;
  logic              in_accept;
  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [FACE_W-1:0] face_sel;
  logic [CI_W-1:0]   coeff_sel;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_count_q      <= RST_FACE_COUNT;
      coeff_count_q     <= RST_COEFF_COUNT;
      match_threshold_q <= RST_MATCH_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FACE_COUNT:      face_count_q      <= cfg_data_i[CNT_W-1:0];
        CFG_COEFF_COUNT:     coeff_count_q     <= cfg_data_i[CNT_W-1:0];
        CFG_MATCH_THRESHOLD: match_threshold_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_accept = in_valid_i && in_ready_o;

  // sequencer: walks faces and coefficients, then label read and result hand-off
  nnfm_ctrl #(
    .MAX_FACES  (MAX_FACES),
    .MAX_COEFFS (MAX_COEFFS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .last_i        (last_i),
    .face_count_i  (face_count_q),
    .coeff_count_i (coeff_count_q),
    .status_i      (status),
    .cmd_o         (cmd),
    .face_o        (face_sel),
    .coeff_o       (coeff_sel)
  );

  // stores, distance pipeline, best tracking and result register
  nnfm_dp #(
    .MAX_FACES  (MAX_FACES),
    .MAX_COEFFS (MAX_COEFFS),
    .COEFF_BITS (COEFF_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_accept_i       (in_accept),
    .func_i            (func_i),
    .face_index_i      (face_index_i),
    .coeff_index_i     (coeff_index_i),
    .coeff_value_i     (coeff_value_i),
    .person_label_i    (person_label_i),
    .match_threshold_i (match_threshold_q),
    .cmd_i             (cmd),
    .face_i            (face_sel),
    .coeff_i           (coeff_sel),
    .status_o          (status),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .nearest_index_o   (nearest_index_o),
    .person_o          (person_o),
    .distance_o        (distance_o),
    .matched_o         (matched_o)
  );

`ifndef SYNTH
  // a finished search never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten");

  // end of search only shows up while the input side is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.best_done |-> !in_ready_o)
    else $error("search completion outside a search");

  // a result is loaded only after the sequencer has left the input side closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !in_ready_o && !cmd.issue)
    else $error("result load while idle or walking");
`endif

endmodule
